FILE: design/assert_macros.svh
// Assertion macros shared by the homogeneous point transform RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define HPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPT_ASSERT_IMP(lbl, ante, cons)
`define HPT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/hpt_pkg.sv
// Package for the homogeneous point transform: widths, register indexes and
// the request and result payload types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH = 16;
    localparam int COEF_LANE = 16;
    localparam int COORD_FRAC = 16;
    localparam int COEF_FRAC = 12;
    localparam int ROW_COUNT = 4;
    localparam int ROW_WIDTH = ROW_COUNT * COEF_LANE;
    localparam int CFG_INDEX_W = 8;
    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_W = PROD_W + 2;
    localparam int QUO_W = 32;
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int ROW_STAGES = 2;
    localparam int PIPE_DEPTH = ROW_STAGES + 1 + DIV_STAGES;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3 = 8'd3;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DIRECTION = 1'b1;

    typedef struct packed {
        logic                           command;
        logic signed [COORD_WIDTH-1:0]  coord_x;
        logic signed [COORD_WIDTH-1:0]  coord_y;
        logic signed [COORD_WIDTH-1:0]  coord_z;
    } hpt_req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  out_x;
        logic signed [COORD_WIDTH-1:0]  out_y;
        logic signed [COORD_WIDTH-1:0]  out_z;
        logic                           w_is_zero;
        logic                           saturated;
    } hpt_rsp_t;

    // What one divide lane hands to the merging stage.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] value;
        logic                   sat;
        logic                   wzero;
    } hpt_lane_res_t;
endpackage
`default_nettype wire

FILE: design/hpt_row_lane.sv
// One matrix row: three products plus the optional translation term, summed
// exactly and returned as magnitude and sign. Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpt_row_lane (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic [hpt_pkg::ROW_WIDTH-1:0]          coefs,
    input  wire logic                                   translate,
    input  wire logic signed [hpt_pkg::COORD_WIDTH-1:0] coord_x,
    input  wire logic signed [hpt_pkg::COORD_WIDTH-1:0] coord_y,
    input  wire logic signed [hpt_pkg::COORD_WIDTH-1:0] coord_z,
    output logic        [hpt_pkg::SUM_W-1:0]            mag,
    output logic                                        neg
);
    logic signed [hpt_pkg::COEF_WIDTH-1:0] c0, c1, c2, c3;
    logic signed [hpt_pkg::PROD_W-1:0] p0_next, p1_next, p2_next, t_next;
    logic signed [hpt_pkg::PROD_W-1:0] p0_reg, p1_reg, p2_reg, t_reg;
    logic signed [hpt_pkg::SUM_W-1:0] sum;
    logic [hpt_pkg::SUM_W-1:0] mag_next, mag_reg;
    logic neg_next, neg_reg;

    always_comb
    begin
        c0 = coefs[0*hpt_pkg::COEF_LANE +: hpt_pkg::COEF_WIDTH];
        c1 = coefs[1*hpt_pkg::COEF_LANE +: hpt_pkg::COEF_WIDTH];
        c2 = coefs[2*hpt_pkg::COEF_LANE +: hpt_pkg::COEF_WIDTH];
        c3 = coefs[3*hpt_pkg::COEF_LANE +: hpt_pkg::COEF_WIDTH];
        p0_next = hpt_pkg::PROD_W'(c0) * hpt_pkg::PROD_W'(coord_x);
        p1_next = hpt_pkg::PROD_W'(c1) * hpt_pkg::PROD_W'(coord_y);
        p2_next = hpt_pkg::PROD_W'(c2) * hpt_pkg::PROD_W'(coord_z);
        // The translation column multiplies a coordinate of exactly one.
        t_next = translate ? (hpt_pkg::PROD_W'(c3) <<< hpt_pkg::COORD_FRAC) : '0;
        sum = hpt_pkg::SUM_W'(p0_reg) + hpt_pkg::SUM_W'(p1_reg)
            + hpt_pkg::SUM_W'(p2_reg) + hpt_pkg::SUM_W'(t_reg);
        neg_next = sum[hpt_pkg::SUM_W-1];
        mag_next = neg_next ? hpt_pkg::SUM_W'(-sum) : hpt_pkg::SUM_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            t_reg <= t_next;
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
endmodule
`default_nettype wire

FILE: design/hpt_div_lane.sv
// One output coordinate: direction scaling or pipelined perspective divide,
// with zero-w and overflow handling and final clamping. Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpt_div_lane (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic                         dir,
    input  wire logic [hpt_pkg::SUM_W-1:0]    mag,
    input  wire logic                         neg,
    input  wire logic [hpt_pkg::SUM_W-1:0]    wmag,
    input  wire logic                         wneg,
    output hpt_pkg::hpt_lane_res_t            res
);
    localparam int DMAG_W = hpt_pkg::SUM_W - hpt_pkg::COEF_FRAC;
    localparam int WIDE_W = hpt_pkg::SUM_W + hpt_pkg::COORD_FRAC;

    typedef struct packed {
        logic [hpt_pkg::SUM_W-1:0]       rem;
        logic [hpt_pkg::SUM_W-1:0]       den;
        logic [hpt_pkg::QUO_W-1:0]       num;
        logic [hpt_pkg::QUO_W-1:0]       quo;
        logic                            qneg;
        logic                            byp;
        logic [hpt_pkg::COORD_WIDTH-1:0] byp_value;
        logic                            byp_sat;
        logic                            wzero;
    } div_stage_t;

    div_stage_t stage_reg [hpt_pkg::DIV_STAGES+1];
    div_stage_t stage_next [hpt_pkg::DIV_STAGES+1];

    logic [DMAG_W-1:0] dmag, dlim, dclamp;
    logic dsat, big, wzero;
    logic [hpt_pkg::SUM_W:0] r2;
    logic [hpt_pkg::QUO_W:0] qlim, qclamp;
    logic qsat;
    div_stage_t last;

    always_comb
    begin
        // Setup: direction result, zero w and quotient overflow decided here.
        dmag = DMAG_W'(mag >> hpt_pkg::COEF_FRAC);
        dlim = neg ? (DMAG_W'(1) << (hpt_pkg::COORD_WIDTH-1))
                   : (DMAG_W'(1) << (hpt_pkg::COORD_WIDTH-1)) - DMAG_W'(1);
        dsat = dmag > dlim;
        dclamp = dsat ? dlim : dmag;
        wzero = (wmag == '0);
        // The quotient needs more than QUO_W bits when mag >= wmag * 2^16.
        big = {WIDE_W'(mag)} >= {wmag, {hpt_pkg::COORD_FRAC{1'b0}}};

        stage_next[0].rem = hpt_pkg::SUM_W'(mag >> hpt_pkg::COORD_FRAC);
        stage_next[0].den = wmag;
        stage_next[0].num = {mag[hpt_pkg::COORD_FRAC-1:0], {hpt_pkg::COORD_FRAC{1'b0}}};
        stage_next[0].quo = '0;
        stage_next[0].qneg = neg ^ wneg;
        stage_next[0].wzero = !dir && wzero;
        stage_next[0].byp = dir || wzero || big;
        if (dir)
        begin
            stage_next[0].byp_value = hpt_pkg::COORD_WIDTH'(neg ? -dclamp : dclamp);
            stage_next[0].byp_sat = dsat;
        end
        else if (wzero)
        begin
            stage_next[0].byp_value = '0;
            stage_next[0].byp_sat = 1'b0;
        end
        else
        begin
            stage_next[0].byp_value = (neg ^ wneg)
                ? {1'b1, {(hpt_pkg::COORD_WIDTH-1){1'b0}}}
                : {1'b0, {(hpt_pkg::COORD_WIDTH-1){1'b1}}};
            stage_next[0].byp_sat = 1'b1;
        end

        // Restoring division, DIV_BITS quotient bits per stage.
        r2 = '0;
        for (int s = 1; s <= hpt_pkg::DIV_STAGES; s++)
        begin
            stage_next[s] = stage_reg[s-1];
            for (int b = 0; b < hpt_pkg::DIV_BITS; b++)
            begin
                r2 = {stage_next[s].rem, stage_next[s].num[hpt_pkg::QUO_W-1]};
                stage_next[s].num = stage_next[s].num << 1;
                if (r2 >= {1'b0, stage_next[s].den})
                begin
                    stage_next[s].rem = hpt_pkg::SUM_W'(r2 - {1'b0, stage_next[s].den});
                    stage_next[s].quo = {stage_next[s].quo[hpt_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    stage_next[s].rem = hpt_pkg::SUM_W'(r2);
                    stage_next[s].quo = {stage_next[s].quo[hpt_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end

        last = stage_reg[hpt_pkg::DIV_STAGES];
        qlim = last.qneg ? ((hpt_pkg::QUO_W+1)'(1) << (hpt_pkg::COORD_WIDTH-1))
                         : ((hpt_pkg::QUO_W+1)'(1) << (hpt_pkg::COORD_WIDTH-1))
                           - (hpt_pkg::QUO_W+1)'(1);
        qsat = {1'b0, last.quo} > qlim;
        qclamp = qsat ? qlim : {1'b0, last.quo};
        if (last.byp)
        begin
            res.value = last.byp_value;
            res.sat = last.byp_sat;
        end
        else
        begin
            res.value = hpt_pkg::COORD_WIDTH'(last.qneg ? -qclamp : qclamp);
            res.sat = qsat;
        end
        res.wzero = last.wzero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= hpt_pkg::DIV_STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide.
// The pipeline has 2 row-sum stages, 1 divide setup stage, 16 divide stages of 2
// quotient bits each and 1 output register.
// Throughput: one request per cycle while the result side is not stalled.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads
// the identity matrix into the four row registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module homogeneous_point_transform (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire hpt_pkg::hpt_req_t                   item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output hpt_pkg::hpt_rsp_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [hpt_pkg::ROW_WIDTH-1:0]       cfg_data
);
    // Matrix rows. Rows 0 to 2 give x, y and z; row 3 gives w.
    logic [hpt_pkg::ROW_WIDTH-1:0] row_coefs_reg [hpt_pkg::ROW_COUNT];

    // The whole pipeline moves together. It advances whenever the output
    // register is empty or its result is being taken this cycle, so a new
    // request can enter in the same cycle that a finished result leaves.
    logic en;
    logic [hpt_pkg::PIPE_DEPTH-1:0] valid_pipe_reg;
    logic [hpt_pkg::ROW_STAGES-1:0] cmd_pipe_reg;
    logic result_valid_reg;
    hpt_pkg::hpt_rsp_t result_reg, result_next;

    logic [hpt_pkg::SUM_W-1:0] row_mag [hpt_pkg::ROW_COUNT];
    logic row_neg [hpt_pkg::ROW_COUNT];
    hpt_pkg::hpt_lane_res_t lane_res [hpt_pkg::ROW_COUNT-1];

    assign en = !result_valid_reg || !result_stall;
    assign item_stall = !en;
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // Configuration writes; an index beyond the last row is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < hpt_pkg::ROW_COUNT; r++)
            begin
                row_coefs_reg[r] <= hpt_pkg::ROW_WIDTH'(64'h1000)
                                    << (r * hpt_pkg::COEF_LANE);
            end
        end
        else if (cfg_valid && cfg_index <= hpt_pkg::REG_ROW3)
        begin
            row_coefs_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // Four row lanes work side by side; translation applies to points only.
    for (genvar r = 0; r < hpt_pkg::ROW_COUNT; r++)
    begin : g_row
        hpt_row_lane u_row (
            .clk       (clk),
            .en        (en),
            .coefs     (row_coefs_reg[r]),
            .translate (item.command == hpt_pkg::CMD_POINT),
            .coord_x   (item.coord_x),
            .coord_y   (item.coord_y),
            .coord_z   (item.coord_z),
            .mag       (row_mag[r]),
            .neg       (row_neg[r])
        );
    end

    // Three divide lanes share the w sum of row 3.
    for (genvar k = 0; k < hpt_pkg::ROW_COUNT - 1; k++)
    begin : g_div
        hpt_div_lane u_div (
            .clk  (clk),
            .en   (en),
            .dir  (cmd_pipe_reg[hpt_pkg::ROW_STAGES-1] == hpt_pkg::CMD_DIRECTION),
            .mag  (row_mag[k]),
            .neg  (row_neg[k]),
            .wmag (row_mag[hpt_pkg::ROW_COUNT-1]),
            .wneg (row_neg[hpt_pkg::ROW_COUNT-1]),
            .res  (lane_res[k])
        );
    end

    // Merging stage: collect the three coordinates, OR the clamp flags and take w_is_zero from lane 0.
    always_comb
    begin
        result_next.out_x = lane_res[0].value;
        result_next.out_y = lane_res[1].value;
        result_next.out_z = lane_res[2].value;
        result_next.w_is_zero = lane_res[0].wzero;
        result_next.saturated = lane_res[0].sat || lane_res[1].sat || lane_res[2].sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            cmd_pipe_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_pipe_reg <= {valid_pipe_reg[hpt_pkg::PIPE_DEPTH-2:0], item_valid};
            cmd_pipe_reg <= {cmd_pipe_reg[hpt_pkg::ROW_STAGES-2:0], item.command};
            result_valid_reg <= valid_pipe_reg[hpt_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    // A full output register that is stalled must hold back new requests.
    `HPT_ASSERT_IMP(a_no_accept_when_full, result_valid && result_stall, item_stall)
    // While requests are held back, nothing moves inside the pipeline.
    `HPT_ASSERT_NXT(a_pipe_frozen, item_stall, $stable(valid_pipe_reg))
    // A point with zero w leaves zero coordinates and no clamp flag.
    `HPT_ASSERT_IMP(a_wzero_clean, result_valid && result.w_is_zero, {result.out_x, result.out_y, result.out_z, result.saturated} == '0)
endmodule
`default_nettype wire
